// ===== rtl/segint_pkg.sv =====
// ----------------------------------------------------------------------------
// segint_pkg: shared constants and types for the segment intersection test
// Holds the tolerance register width and the per-item decision flags.
// ----------------------------------------------------------------------------
package segint_pkg;

  // width of the collinear tolerance register; the value is unsigned Q19.32
  localparam int unsigned TolWidth = 51;

  // decision flags formed from the sums, ahead of the final select
  typedef struct packed {
    logic coll;      // both cross products below the tolerance
    logic straddle;  // straddle test passed
    logic near_d;    // collinear check around end point d passed
    logic near_c;    // collinear check around start point c passed
  } flags_t;

endpackage

// ===== rtl/segint_pair_if.sv =====
// ----------------------------------------------------------------------------
// segint_pair_if: input channel carrying the end points of two segments
// Valid/ready handshake with the eight signed Q8.16 coordinates.
// ----------------------------------------------------------------------------
interface segint_pair_if #(
  parameter int unsigned COORD_WIDTH = 24
);
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] a_x;
  logic signed [COORD_WIDTH-1:0] a_y;
  logic signed [COORD_WIDTH-1:0] b_x;
  logic signed [COORD_WIDTH-1:0] b_y;
  logic signed [COORD_WIDTH-1:0] c_x;
  logic signed [COORD_WIDTH-1:0] c_y;
  logic signed [COORD_WIDTH-1:0] d_x;
  logic signed [COORD_WIDTH-1:0] d_y;

  modport source (
    output valid, a_x, a_y, b_x, b_y, c_x, c_y, d_x, d_y,
    input  ready
  );

  modport sink (
    input  valid, a_x, a_y, b_x, b_y, c_x, c_y, d_x, d_y,
    output ready
  );
endinterface

// ===== rtl/segint_result_if.sv =====
// ----------------------------------------------------------------------------
// segint_result_if: output channel carrying the intersection verdict
// Valid/ready handshake with a single result bit.
// ----------------------------------------------------------------------------
interface segint_result_if;
  logic valid;
  logic ready;
  logic intersects;

  modport source (
    output valid, intersects,
    input  ready
  );

  modport sink (
    input  valid, intersects,
    output ready
  );
endinterface

// ===== rtl/segint_cfg_if.sv =====
// ----------------------------------------------------------------------------
// segint_cfg_if: configuration write channel
// Valid/ready handshake carrying the collinear tolerance value.
// ----------------------------------------------------------------------------
interface segint_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [segint_pkg::TolWidth-1:0]   collinear_tolerance;

  modport source (
    output valid, collinear_tolerance,
    input  ready
  );

  modport sink (
    input  valid, collinear_tolerance,
    output ready
  );
endinterface

// ===== rtl/segment_intersection_test.sv =====
// ----------------------------------------------------------------------------
// segment_intersection_test: 2-D closed segment intersection test
// Decides whether segments AB and CD meet, with a collinear special case.
// ----------------------------------------------------------------------------
// Usage:
//   pair_i   : one transfer per segment pair (a, b, c, d points, signed Q8.16)
//   result_o : one transfer per pair, intersects = 1 when the segments meet
//   cfg_i    : writes collinear_tolerance, always ready; write it only while
//              no pair is in flight
// Five registers lie between a pair transfer and its result: differences
// (loaded at the transfer edge), products, sums, compares, output register.
// Throughput is one pair per cycle while the receiver takes results; the
// multiplier stage forms 24 products of COORD_WIDTH+1 bit differences.
// Each stage holds its own valid bit and advances when the stage after it is
// empty or moving, so bubbles close up while the receiver stalls and input
// stays ready until all five stages hold a pair.
// Reset clears all valid bits and sets the tolerance to 0; with a tolerance
// of 0 every pair goes through the straddle test.
// ----------------------------------------------------------------------------
module segment_intersection_test #(
  parameter int unsigned COORD_WIDTH = 24
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  segint_pair_if.sink      pair_i,
  segint_cfg_if.sink       cfg_i,
  segint_result_if.source  result_o
);
  import segint_pkg::*;

  localparam int unsigned DW   = COORD_WIDTH + 1;   // difference width
  localparam int unsigned PW   = 2 * DW;            // product and sum width
  localparam int unsigned MW   = PW - 1;            // magnitude width
  localparam int unsigned CMPW = (MW > TolWidth) ? MW : TolWidth;

  // difference slots
  localparam int unsigned IAbX = 0;
  localparam int unsigned IAbY = 1;
  localparam int unsigned IAcX = 2;
  localparam int unsigned IAcY = 3;
  localparam int unsigned IAdX = 4;
  localparam int unsigned IAdY = 5;
  localparam int unsigned ICbX = 6;
  localparam int unsigned ICbY = 7;
  localparam int unsigned ICdX = 8;
  localparam int unsigned ICdY = 9;
  localparam int unsigned IDbX = 10;
  localparam int unsigned IDbY = 11;
  localparam int unsigned NDiff = 12;

  // sum slots; the first NCross are cross products (difference of products)
  localparam int unsigned SD1    = 0;
  localparam int unsigned SD2    = 1;
  localparam int unsigned SS1    = 2;
  localparam int unsigned SS3    = 3;
  localparam int unsigned SS4    = 4;
  localparam int unsigned SDotAd = 5;
  localparam int unsigned SDotAc = 6;
  localparam int unsigned SSqDa  = 7;
  localparam int unsigned SSqDb  = 8;
  localparam int unsigned SSqDc  = 9;
  localparam int unsigned SSqCa  = 10;
  localparam int unsigned SSqCb  = 11;
  localparam int unsigned NSum   = 12;
  localparam int unsigned NCross = 5;
  localparam int unsigned NProd  = 2 * NSum;

  // operand slots of each product, two products per sum
  localparam int unsigned MulA [NProd] = '{
    IAbX, IAbY,  IAdX, IAdY,  IAcX, IAcY,  ICbX, ICbY,  ICdY, ICdX,
    ICdX, ICdY,  ICdX, ICdY,
    IAdX, IAdY,  IDbX, IDbY,  ICdX, ICdY,  IAcX, IAcY,  ICbX, ICbY
  };
  localparam int unsigned MulB [NProd] = '{
    ICdY, ICdX,  IAbY, IAbX,  IAbY, IAbX,  ICdY, ICdX,  IAcX, IAcY,
    IAdX, IAdY,  IAcX, IAcY,
    IAdX, IAdY,  IDbX, IDbY,  ICdX, ICdY,  IAcX, IAcY,  ICbX, ICbY
  };

  // stage valid bits: 1 diffs, 2 products, 3 sums, 4 flags, 5 output
  logic v1_q, v2_q, v3_q, v4_q, v5_q;
  logic en1, en2, en3, en4, en5;

  logic signed [DW-1:0] diff_d [NDiff];
  logic signed [DW-1:0] diff_q [NDiff];
  logic signed [PW-1:0] prod_d [NProd];
  logic signed [PW-1:0] prod_q [NProd];
  logic signed [PW-1:0] sum_d  [NSum];
  logic signed [PW-1:0] sum_q  [NSum];
  flags_t               flags_d, flags_q;
  logic                 hit_d, hit_q;
  logic [TolWidth-1:0]  tol_q;

  logic [PW-1:0]   d1_abs, d2_abs;
  logic [CMPW-1:0] d1_mag, d2_mag, tol_ext;
  logic            t1_ok, t2_ok;

  // stage enables: a stage moves when it is empty or the next one moves
  assign en5 = !v5_q || result_o.ready;
  assign en4 = !v4_q || en5;
  assign en3 = !v3_q || en4;
  assign en2 = !v2_q || en3;
  assign en1 = !v1_q || en2;

  assign pair_i.ready     = en1;
  assign cfg_i.ready      = 1'b1;
  assign result_o.valid   = v5_q;
  assign result_o.intersects = hit_q;

  // valid bits and tolerance register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q  <= 1'b0;
      v2_q  <= 1'b0;
      v3_q  <= 1'b0;
      v4_q  <= 1'b0;
      v5_q  <= 1'b0;
      tol_q <= '0;
    end else begin
      if (en1) v1_q <= pair_i.valid;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
      if (en4) v4_q <= v3_q;
      if (en5) v5_q <= v4_q;
      if (cfg_i.valid) tol_q <= cfg_i.collinear_tolerance;
    end
  end

  // stage 1: coordinate differences
  always_comb begin
    diff_d[IAbX] = DW'(pair_i.b_x) - DW'(pair_i.a_x);
    diff_d[IAbY] = DW'(pair_i.b_y) - DW'(pair_i.a_y);
    diff_d[IAcX] = DW'(pair_i.c_x) - DW'(pair_i.a_x);
    diff_d[IAcY] = DW'(pair_i.c_y) - DW'(pair_i.a_y);
    diff_d[IAdX] = DW'(pair_i.d_x) - DW'(pair_i.a_x);
    diff_d[IAdY] = DW'(pair_i.d_y) - DW'(pair_i.a_y);
    diff_d[ICbX] = DW'(pair_i.b_x) - DW'(pair_i.c_x);
    diff_d[ICbY] = DW'(pair_i.b_y) - DW'(pair_i.c_y);
    diff_d[ICdX] = DW'(pair_i.d_x) - DW'(pair_i.c_x);
    diff_d[ICdY] = DW'(pair_i.d_y) - DW'(pair_i.c_y);
    diff_d[IDbX] = DW'(pair_i.d_x) - DW'(pair_i.b_x);
    diff_d[IDbY] = DW'(pair_i.d_y) - DW'(pair_i.b_y);
  end

  always_ff @(posedge clk_i) begin
    if (en1 && pair_i.valid) begin
      diff_q <= diff_d;
    end
  end

  // stage 2: one multiplier per product
  always_comb begin
    for (int i = 0; i < NProd; i++) begin
      prod_d[i] = PW'(diff_q[MulA[i]]) * PW'(diff_q[MulB[i]]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en2 && v1_q) begin
      prod_q <= prod_d;
    end
  end

  // stage 3: cross products subtract, dot products and squares add
  always_comb begin
    for (int i = 0; i < NSum; i++) begin
      if (i < NCross) begin
        sum_d[i] = prod_q[2*i] - prod_q[2*i+1];
      end else begin
        sum_d[i] = prod_q[2*i] + prod_q[2*i+1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en3 && v2_q) begin
      sum_q <= sum_d;
    end
  end

  // stage 4: tolerance, sign and distance compares
  always_comb begin
    d1_abs  = sum_q[SD1][PW-1] ? PW'(-sum_q[SD1]) : PW'(sum_q[SD1]);
    d2_abs  = sum_q[SD2][PW-1] ? PW'(-sum_q[SD2]) : PW'(sum_q[SD2]);
    d1_mag  = CMPW'(d1_abs[MW-1:0]);
    d2_mag  = CMPW'(d2_abs[MW-1:0]);
    tol_ext = CMPW'(tol_q);

    // AB x AD is the negation of d2, so opposite signs mean a nonnegative product
    t1_ok = (sum_q[SS1] == '0) || (sum_q[SD2] == '0) ||
            (sum_q[SS1][PW-1] != sum_q[SD2][PW-1]);
    t2_ok = (sum_q[SS3] == '0) || (sum_q[SS4] == '0) ||
            (sum_q[SS3][PW-1] == sum_q[SS4][PW-1]);

    flags_d.coll     = (d1_mag < tol_ext) && (d2_mag < tol_ext);
    flags_d.straddle = t1_ok && t2_ok;
    flags_d.near_d   = !sum_q[SDotAd][PW-1] &&
                       ((sum_q[SSqDa] <= sum_q[SSqDc]) || (sum_q[SSqDb] <= sum_q[SSqDc]));
    flags_d.near_c   = ((sum_q[SDotAc][PW-1]) || (sum_q[SDotAc] == '0)) &&
                       ((sum_q[SSqCa] <= sum_q[SSqDc]) || (sum_q[SSqCb] <= sum_q[SSqDc]));
  end

  always_ff @(posedge clk_i) begin
    if (en4 && v3_q) begin
      flags_q <= flags_d;
    end
  end

  // stage 5: branch select into the output register
  assign hit_d = flags_q.coll ? (flags_q.near_d || flags_q.near_c) : flags_q.straddle;

  always_ff @(posedge clk_i) begin
    if (en5 && v4_q) begin
      hit_q <= hit_d;
    end
  end

  // with the output register empty the whole pipe can move
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !v5_q |-> pair_i.ready)
    else $error("input not ready with empty output register");

  // zero tolerance never selects the collinear branch
  a_zero_tol_no_coll: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v4_q && (tol_q == '0)) |-> !flags_q.coll)
    else $error("collinear branch taken with zero tolerance");

  // squared distances are never negative
  a_sq_nonneg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v3_q |-> (!sum_q[SSqDa][PW-1] && !sum_q[SSqDb][PW-1] && !sum_q[SSqDc][PW-1] &&
              !sum_q[SSqCa][PW-1] && !sum_q[SSqCb][PW-1]))
    else $error("negative squared distance");

  // a stalled flag stage keeps its item
  a_flags_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v4_q && !en5) |=> (v4_q && $stable(flags_q)))
    else $error("flag stage lost its item under stall");

endmodule
